// ----- rtl/ebc_pkg.sv -----
package ebc_pkg;

   localparam int MOD_BITS = 32;
   localparam int CNT_W    = $clog2(MOD_BITS);
   localparam int CSR_IDX_W = 3;

   localparam logic CMD_ENCRYPT = 1'b0;
   localparam logic CMD_DECRYPT = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_MODULUS     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GENERATOR   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PUBLIC_KEY  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PRIVATE_KEY = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SESSION_KEY = 3'd4;

   typedef struct packed {
      logic        command;
      logic [7:0]  message_byte;
      logic [31:0] cipher_a;
      logic [31:0] cipher_b;
   } req_type;

   typedef struct packed {
      logic [31:0] out_a;
      logic [31:0] out_b;
      logic [7:0]  plain_byte;
   } rsp_type;

endpackage

// ----- rtl/elgamal_byte_cipher_top.sv -----
// ElGamal byte cipher, one item at a time.
// req channel (req_valid/req_ready/req_data): command 0 encrypts message_byte,
// giving out_a = g^k mod p and out_b = (y^k mod p)*m mod p; command 1 decrypts
// (cipher_a, cipher_b), giving plain_byte = low 8 bits of b*a^(p-1-x) mod p.
// rsp channel (rsp_valid/rsp_ready/rsp_data) carries one result item per item.
// csr channel writes modulus, generator, public key, private key, session key
// by index 0..4; it is ready only while no item is being worked on.
// All arithmetic runs through one modular multiplier that handles one bit of
// its multiplier operand per cycle, and every exponent bit also passes through
// a check state. An encrypt takes three reductions, two exponentiations and a
// final multiply: with a full 32-bit session key up to 132 multiplies. A
// decrypt needs about half as many. Its exponent p-1-x is replaced by 0 when x >= p.
// Exponent bits that are zero skip the multiply and cost only a squaring.
// A modulus below two gives an all-zero result.
// The finished result sits in an output register; the next item is accepted
// while it waits, and if the receiver still stalls when that item is done,
// the sequencer holds until the output register frees up.
// Reset (synchronous) restores the register defaults and empties the block.
module elgamal_byte_cipher_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  ebc_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output ebc_pkg::rsp_type                rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ebc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [31:0]                     csr_wdata
);
   import ebc_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_RED_BASE,
      S_POW_CHK,
      S_POW_MUL,
      S_POW_SQ,
      S_RED_OP,
      S_FINAL,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic [MOD_BITS-1:0] x;
      logic [MOD_BITS-1:0] y;
      logic [MOD_BITS-1:0] r;
      logic [CNT_W-1:0]    cnt;
   } mul_type;

   state_type           state_ff, state_in;
   mul_type             mul_ff, mul_in;
   logic [31:0]         modulus_ff, generator_ff, public_key_ff, private_key_ff;
   logic [31:0]         session_key_ff;
   logic                cmd_ff, cmd_in;
   logic                pass_ff, pass_in;
   logic [MOD_BITS-1:0] acc_ff, acc_in;
   logic [MOD_BITS-1:0] sq_ff, sq_in;
   logic [MOD_BITS-1:0] exp_ff, exp_in;
   logic [MOD_BITS-1:0] ra_ff, ra_in;
   logic [MOD_BITS-1:0] b_ff, b_in;
   logic [7:0]          m_ff, m_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;
   rsp_type             res_ff, res_in;

   logic [MOD_BITS-1:0] mod_w, gen_w, pub_w, priv_w, ses_w, dec_exp;
   logic [MOD_BITS+1:0] mul_t, mul_p1, mul_p2;
   logic [MOD_BITS-1:0] mul_next;
   logic                mul_last;
   logic                mod_small;

   function automatic mul_type mul_start(input logic [MOD_BITS-1:0] x,
                                         input logic [MOD_BITS-1:0] y);
      mul_type m;
      m.x   = x;
      m.y   = y;
      m.r   = '0;
      m.cnt = CNT_W'(MOD_BITS - 1);
      return m;
   endfunction

   assign mod_w  = modulus_ff[MOD_BITS-1:0];
   assign gen_w  = generator_ff[MOD_BITS-1:0];
   assign pub_w  = public_key_ff[MOD_BITS-1:0];
   assign priv_w = private_key_ff[MOD_BITS-1:0];
   assign ses_w  = session_key_ff[MOD_BITS-1:0];
   assign mod_small = (mod_w[MOD_BITS-1:1] == '0);
   assign dec_exp = (priv_w < mod_w) ? (mod_w - MOD_BITS'(1) - priv_w) : '0;

   // one bit of interleaved modular multiplication
   always_comb begin
      mul_p1 = {2'b00, mod_w};
      mul_p2 = {1'b0, mod_w, 1'b0};
      mul_t  = {1'b0, mul_ff.r, 1'b0}
             + (mul_ff.y[MOD_BITS-1] ? {2'b00, mul_ff.x} : '0);
      if (mul_t >= mul_p2) begin
         mul_next = MOD_BITS'(mul_t - mul_p2);
      end else if (mul_t >= mul_p1) begin
         mul_next = MOD_BITS'(mul_t - mul_p1);
      end else begin
         mul_next = MOD_BITS'(mul_t);
      end
      mul_last = (mul_ff.cnt == '0);
   end

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      mul_in       = mul_ff;
      cmd_in       = cmd_ff;
      pass_in      = pass_ff;
      acc_in       = acc_ff;
      sq_in        = sq_ff;
      exp_in       = exp_ff;
      ra_in        = ra_ff;
      b_in         = b_ff;
      m_in         = m_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (state_ff != S_IDLE && state_ff != S_POW_CHK && state_ff != S_FINISH) begin
         mul_in.r   = mul_next;
         mul_in.y   = {mul_ff.y[MOD_BITS-2:0], 1'b0};
         mul_in.cnt = mul_ff.cnt - CNT_W'(1);
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in  = req_data.command;
               m_in    = req_data.message_byte;
               b_in    = req_data.cipher_b[MOD_BITS-1:0];
               pass_in = 1'b0;
               acc_in  = MOD_BITS'(1);
               if (mod_small) begin
                  res_in   = '0;
                  state_in = S_FINISH;
               end else if (req_data.command == CMD_DECRYPT) begin
                  exp_in   = dec_exp;
                  mul_in   = mul_start(MOD_BITS'(1), req_data.cipher_a[MOD_BITS-1:0]);
                  state_in = S_RED_BASE;
               end else begin
                  exp_in   = ses_w;
                  mul_in   = mul_start(MOD_BITS'(1), gen_w);
                  state_in = S_RED_BASE;
               end
            end
         end
         S_RED_BASE: begin
            if (mul_last) begin
               sq_in    = mul_next;
               state_in = S_POW_CHK;
            end
         end
         S_POW_CHK: begin
            if (exp_ff == '0) begin
               if (cmd_ff == CMD_ENCRYPT && !pass_ff) begin
                  ra_in    = acc_ff;
                  pass_in  = 1'b1;
                  acc_in   = MOD_BITS'(1);
                  exp_in   = ses_w;
                  mul_in   = mul_start(MOD_BITS'(1), pub_w);
                  state_in = S_RED_BASE;
               end else if (cmd_ff == CMD_ENCRYPT) begin
                  mul_in   = mul_start(MOD_BITS'(1), MOD_BITS'(m_ff));
                  state_in = S_RED_OP;
               end else begin
                  mul_in   = mul_start(MOD_BITS'(1), b_ff);
                  state_in = S_RED_OP;
               end
            end else if (exp_ff[0]) begin
               mul_in   = mul_start(acc_ff, sq_ff);
               state_in = S_POW_MUL;
            end else begin
               mul_in   = mul_start(sq_ff, sq_ff);
               state_in = S_POW_SQ;
            end
         end
         S_POW_MUL: begin
            if (mul_last) begin
               acc_in   = mul_next;
               mul_in   = mul_start(sq_ff, sq_ff);
               state_in = S_POW_SQ;
            end
         end
         S_POW_SQ: begin
            if (mul_last) begin
               sq_in    = mul_next;
               exp_in   = exp_ff >> 1;
               state_in = S_POW_CHK;
            end
         end
         S_RED_OP: begin
            if (mul_last) begin
               mul_in   = mul_start(acc_ff, mul_next);
               state_in = S_FINAL;
            end
         end
         S_FINAL: begin
            if (mul_last) begin
               if (cmd_ff == CMD_ENCRYPT) begin
                  res_in.out_a      = 32'(ra_ff);
                  res_in.out_b      = 32'(mul_next);
                  res_in.plain_byte = '0;
               end else begin
                  res_in.out_a      = '0;
                  res_in.out_b      = '0;
                  res_in.plain_byte = mul_next[7:0];
               end
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         modulus_ff     <= 32'd257;
         generator_ff   <= 32'd3;
         public_key_ff  <= 32'd1;
         private_key_ff <= 32'd0;
         session_key_ff <= 32'd1;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_MODULUS:     modulus_ff     <= csr_wdata;
               CSR_GENERATOR:   generator_ff   <= csr_wdata;
               CSR_PUBLIC_KEY:  public_key_ff  <= csr_wdata;
               CSR_PRIVATE_KEY: private_key_ff <= csr_wdata;
               CSR_SESSION_KEY: session_key_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
      mul_ff      <= mul_in;
      cmd_ff      <= cmd_in;
      pass_ff     <= pass_in;
      acc_ff      <= acc_in;
      sq_ff       <= sq_in;
      exp_ff      <= exp_in;
      ra_ff       <= ra_in;
      b_ff        <= b_in;
      m_ff        <= m_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != S_IDLE))
      else $error("item accepted but sequencer stayed idle");

   pow_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_POW_CHK) |-> (acc_ff < mod_w && sq_ff < mod_w))
      else $error("exponentiation operand not reduced");

   mul_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_POW_MUL || state_ff == S_POW_SQ || state_ff == S_FINAL)
      |-> (mul_ff.r < mod_w && mul_ff.x < mod_w))
      else $error("multiplier partial result out of range");

   result_fields_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.plain_byte == '0
                        || (rsp_data_ff.out_a == '0 && rsp_data_ff.out_b == '0)))
      else $error("encrypt and decrypt fields both set");

endmodule

// ----- sim/elgamal_byte_cipher_checker.sv -----
module elgamal_byte_cipher_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  ebc_pkg::req_type              req_data,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  ebc_pkg::rsp_type              rsp_data,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [ebc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                   csr_wdata,
   output int                            fail_count,
   output int                            pending,
   output int                            results_checked
);
   timeunit 1ns;
   timeprecision 1ps;
   import ebc_pkg::*;

   localparam logic [63:0] OP_MASK = (64'd1 << MOD_BITS) - 64'd1;

   logic [31:0] cfg_modulus;
   logic [31:0] cfg_generator;
   logic [31:0] cfg_public_key;
   logic [31:0] cfg_private_key;
   logic [31:0] cfg_session_key;

   rsp_type cipher_expect_q[$];

   // square and multiply, operands stay below p so products fit in 64 bits
   function automatic logic [63:0] pow_residue(logic [63:0] base, logic [63:0] e,
                                               logic [63:0] p);
      logic [63:0] acc;
      logic [63:0] sq;
      acc = 64'd1 % p;
      sq  = base % p;
      while (e != 64'd0) begin
         if (e[0]) begin
            acc = (acc * sq) % p;
         end
         sq = (sq * sq) % p;
         e  = e >> 1;
      end
      return acc;
   endfunction

   function automatic rsp_type predict_cipher(req_type r);
      rsp_type     res;
      logic [63:0] p;
      logic [63:0] k;
      logic [63:0] x;
      logic [63:0] e;
      logic [63:0] shared;
      logic [63:0] b_red;
      res = '0;
      p   = 64'(cfg_modulus) & OP_MASK;
      if (p >= 64'd2) begin
         if (r.command == CMD_ENCRYPT) begin
            k = 64'(cfg_session_key) & OP_MASK;
            res.out_a = 32'(pow_residue(64'(cfg_generator) & OP_MASK, k, p));
            shared    = pow_residue(64'(cfg_public_key) & OP_MASK, k, p);
            res.out_b = 32'((shared * (64'(r.message_byte) % p)) % p);
         end else begin
            x     = 64'(cfg_private_key) & OP_MASK;
            e     = (x < p) ? (p - 64'd1 - x) : 64'd0;
            b_red = (64'(r.cipher_b) & OP_MASK) % p;
            res.plain_byte =
               8'((b_red * pow_residue(64'(r.cipher_a) & OP_MASK, e, p)) % p);
         end
      end
      return res;
   endfunction

   task automatic flag_error(string msg);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%0t ns: %s", $time, msg);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         cfg_modulus     <= 32'd257;
         cfg_generator   <= 32'd3;
         cfg_public_key  <= 32'd1;
         cfg_private_key <= 32'd0;
         cfg_session_key <= 32'd1;
         cipher_expect_q.delete();
         fail_count      = 0;
         results_checked = 0;
         pending         <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (cipher_expect_q.size() == 0) begin
               flag_error($sformatf("unexpected result item a=%h b=%h byte=%h",
                                    rsp_data.out_a, rsp_data.out_b, rsp_data.plain_byte));
            end else begin
               want = cipher_expect_q.pop_front();
               results_checked++;
               if (rsp_data.out_a !== want.out_a) begin
                  flag_error($sformatf("out_a expected %h got %h", want.out_a,
                                       rsp_data.out_a));
               end
               if (rsp_data.out_b !== want.out_b) begin
                  flag_error($sformatf("out_b expected %h got %h", want.out_b,
                                       rsp_data.out_b));
               end
               if (rsp_data.plain_byte !== want.plain_byte) begin
                  flag_error($sformatf("plain_byte expected %h got %h", want.plain_byte,
                                       rsp_data.plain_byte));
               end
            end
         end
         if (req_valid && req_ready) begin
            cipher_expect_q.push_back(predict_cipher(req_data));
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MODULUS: begin
                  cfg_modulus <= csr_wdata;
               end
               CSR_GENERATOR: begin
                  cfg_generator <= csr_wdata;
               end
               CSR_PUBLIC_KEY: begin
                  cfg_public_key <= csr_wdata;
               end
               CSR_PRIVATE_KEY: begin
                  cfg_private_key <= csr_wdata;
               end
               CSR_SESSION_KEY: begin
                  cfg_session_key <= csr_wdata;
               end
               default: begin
               end
            endcase
         end
         pending <= cipher_expect_q.size();
      end
   end

endmodule

// ----- sim/elgamal_byte_cipher_top_tb.sv -----
module elgamal_byte_cipher_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ebc_pkg::*;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   rsp_type              rsp_data;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [31:0]          csr_wdata;

   int          fail_count;
   int          pending;
   int          results_checked;
   logic        idle_en;
   logic [31:0] cur_modulus;
   int          n_encrypt;
   int          n_decrypt;
   int          n_settings;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   elgamal_byte_cipher_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   elgamal_byte_cipher_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .pending         (pending),
      .results_checked (results_checked)
   );

   // valid stays up across back-to-back items
   task automatic push_req(input logic cmd, input logic [7:0] m, input logic [31:0] a,
                           input logic [31:0] b);
      int gap;
      gap = idle_en ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data <= '{command: cmd, message_byte: m, cipher_a: a, cipher_b: b};
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      if (cmd == CMD_ENCRYPT) begin
         n_encrypt++;
      end else begin
         n_decrypt++;
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_all(input logic [31:0] p, input logic [31:0] g, input logic [31:0] y,
                          input logic [31:0] x, input logic [31:0] k);
      drain();
      write_reg(CSR_MODULUS, p);
      write_reg(CSR_GENERATOR, g);
      write_reg(CSR_PUBLIC_KEY, y);
      write_reg(CSR_PRIVATE_KEY, x);
      write_reg(CSR_SESSION_KEY, k);
      cur_modulus = p;
      n_settings++;
   endtask

   function automatic logic [31:0] pick_operand(input logic [31:0] p);
      case ($urandom_range(0, 7)) inside
         0: return 32'd0;
         1: return '1;
         2: return p;
         3: return p - 32'd1;
         [4:5]: return (p == 32'd0) ? $urandom : $urandom % p;
         default: return $urandom;
      endcase
   endfunction

   // result side: random stall before each item, none while idling is off
   initial begin
      int stall;
      rsp_ready = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         stall = idle_en ? $urandom_range(0, 9) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      logic [31:0] p;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_valid   = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      idle_en     = 1'b1;
      cur_modulus = 32'd257;
      n_encrypt   = 0;
      n_decrypt   = 0;
      n_settings  = 1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // register defaults straight out of reset
      push_req(CMD_ENCRYPT, 8'h00, 32'd0, 32'd0);
      push_req(CMD_ENCRYPT, 8'hff, 32'd0, 32'd0);
      push_req(CMD_DECRYPT, 8'h00, 32'd0, 32'd0);
      push_req(CMD_DECRYPT, 8'hff, '1, '1);

      // small textbook group, round trip plus unreduced operands
      set_all(32'd23, 32'd5, 32'd8, 32'd6, 32'd3);
      push_req(CMD_ENCRYPT, 8'd10, 32'd0, 32'd0);
      push_req(CMD_ENCRYPT, 8'd22, $urandom, $urandom);
      push_req(CMD_DECRYPT, 8'd0, 32'd10, 32'd14);
      push_req(CMD_DECRYPT, 8'($urandom_range(0, 255)), 32'd23, 32'd46);

      // modulus below two, with writes to unused register slots
      set_all(32'd0, $urandom, $urandom, $urandom, $urandom);
      for (int i = CSR_SESSION_KEY + 1; i < (1 << CSR_IDX_W); i++) begin
         write_reg(CSR_IDX_W'(i), $urandom);
      end
      push_req(CMD_ENCRYPT, 8'haa, $urandom, $urandom);
      push_req(CMD_DECRYPT, 8'h55, $urandom, $urandom);
      set_all(32'd1, $urandom, $urandom, $urandom, $urandom);
      push_req(CMD_ENCRYPT, 8'h7f, 32'd0, 32'd0);
      push_req(CMD_DECRYPT, 8'h00, $urandom, $urandom);

      // private key at or beyond the modulus
      set_all(32'd257, 32'd3, 32'd9, 32'd257, 32'd5);
      push_req(CMD_DECRYPT, 8'h00, 32'd5, 32'd300);
      set_all(32'd257, 32'd3, 32'd9, '1, 32'd5);
      push_req(CMD_DECRYPT, 8'h00, '1, 32'd1234);

      // zero exponents, including a zero base
      set_all(32'd257, 32'd0, 32'd0, 32'd256, 32'd0);
      push_req(CMD_ENCRYPT, 8'd7, 32'd0, 32'd0);
      push_req(CMD_DECRYPT, 8'd0, 32'd0, 32'd99);

      // all-ones registers but for a public key of all-ones minus one
      set_all('1, '1, 32'hffff_fffe, '1, '1);
      push_req(CMD_ENCRYPT, 8'hff, 32'd0, 32'd0);
      push_req(CMD_ENCRYPT, 8'h01, 32'd0, 32'd0);
      push_req(CMD_DECRYPT, 8'h00, '1, '1);

      // largest 32-bit prime, full-length exponents
      set_all(32'hffff_fffb, 32'd2, $urandom, 32'd0, '1);
      push_req(CMD_ENCRYPT, 8'h80, 32'd0, 32'd0);
      push_req(CMD_DECRYPT, 8'h00, 32'hffff_fffa, 32'h1234_5678);

      // smallest usable modulus
      set_all(32'd2, 32'd3, 32'd5, 32'd1, 32'd7);
      push_req(CMD_ENCRYPT, 8'hff, 32'd0, 32'd0);
      push_req(CMD_DECRYPT, 8'h00, 32'd3, 32'd1);

      for (int ph = 0; ph < 10; ph++) begin
         case ($urandom_range(0, 7))
            0: p = $urandom_range(0, 3);
            1: p = 32'hffff_fffb;
            2: p = '1;
            3: p = $urandom_range(2, 300);
            4: p = $urandom_range(2, 70000);
            default: p = $urandom | 32'd1;
         endcase
         set_all(p, pick_operand(p), pick_operand(p), pick_operand(p), pick_operand(p));
         idle_en = ($urandom_range(0, 3) != 0);
         for (int i = 0; i < 11; i++) begin
            push_req(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                     pick_operand(cur_modulus), pick_operand(cur_modulus));
         end
      end

      drain();
      repeat (50) @(posedge clock);
      $display("sent %0d encrypt and %0d decrypt items under %0d register settings",
               n_encrypt, n_decrypt, n_settings);
      $display("%0d result items checked, %0d mismatches", results_checked, fail_count);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #(40_000_000);
      $display("run timed out with %0d results outstanding", pending);
      $display("*** FAILED ***");
      $finish;
   end

endmodule
